>>> rtl/core/smoc_pkg.sv
`default_nettype none

package smoc_pkg;

    localparam int RING_DEPTH    = 50;
    localparam int HISTORY_DEPTH = 10;
    localparam int CODE_BITS     = 12;

    localparam int SAMPLE_W  = 10;
    localparam int VAL_W     = 11;
    localparam int PERIOD_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 11;
    localparam int GAIN_W    = 14;
    localparam int FRAC_BITS = 12;
    localparam int VAL_MAX   = 2047;

    localparam logic [GAIN_W-1:0] GAIN_CURR_SCALE = 14'd6212;
    localparam logic [GAIN_W-1:0] GAIN_VOLT_SCALE = 14'd5867;
    localparam logic [GAIN_W-1:0] GAIN_I_NORMAL   = 14'd9970;
    localparam logic [GAIN_W-1:0] GAIN_V_NORMAL   = 14'd7520;
    localparam logic [GAIN_W-1:0] GAIN_I_PROTECT  = 14'd9421;
    localparam logic [GAIN_W-1:0] GAIN_V_PROTECT  = 14'd8192;

    localparam logic [VAL_W-1:0] VOLT_OFFSET = 11'd10;
    localparam logic [VAL_W-1:0] CURR_OFFSET = 11'd70;

    localparam logic [VAL_W-1:0]    THRESHOLD_RESET = 11'd1080;
    localparam logic [PERIOD_W-1:0] DAC_PERIOD_RESET = 8'd30;
    localparam logic [PERIOD_W-1:0] CHECK_PERIOD_RESET = 8'd200;

    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAC_PERIOD        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD      = 2'd2;

    localparam logic CH_CURR = 1'b0;
    localparam logic CH_VOLT = 1'b1;

    localparam int CODE_MAX = (1 << CODE_BITS) - 1;
    localparam logic [CODE_BITS-1:0] CODE_RESET = CODE_BITS'(500);

    // ring averaging: exact divide by a constant through a rounded-up reciprocal
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int SUM_W       = $clog2(RING_DEPTH * VAL_MAX + 1);
    localparam int AVG_SHIFT   = SUM_W + $clog2(RING_DEPTH);
    localparam longint AVG_RECIP =
        ((longint'(1) << AVG_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;
    localparam int AVG_RECIP_W = $clog2(AVG_RECIP + 1);
    localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;

    // history mean
    localparam int HSLOT_W   = $clog2(HISTORY_DEPTH);
    localparam int HSUM_W    = $clog2(HISTORY_DEPTH * VAL_MAX + 1);
    localparam int H_SHIFT   = HSUM_W + $clog2(HISTORY_DEPTH);
    localparam longint H_RECIP =
        ((longint'(1) << H_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
    localparam int H_RECIP_W = $clog2(H_RECIP + 1);
    localparam int H_PROD_W  = HSUM_W + H_RECIP_W;

    localparam int SCALE_W = SAMPLE_W + GAIN_W;
    localparam int PROD_W  = VAL_W + GAIN_W;
    localparam int MIX_W   = PROD_W + 1;

endpackage

`default_nettype wire

>>> rtl/core/supply_monitor_overcurrent_ctrl_core.sv
// Supply monitor with overcurrent protection.
// Input channel (in_valid/in_ready, sample): one converter sample per item.
// Items alternate between voltage and current; the first item after reset
// is a voltage sample. Each item is scaled into its channel's ring, the
// channel averages are updated, the overcurrent history is checked every
// check_period items and the control code goes out every dac_period items.
// Output channel (out_valid/out_ready): exactly one result item per input.
// One item is taken per cycle while the output is not stalled, through the
// seven-stage pipeline (ring update, average, history, mode, products,
// saturation, result).
// Each ring lives in a single-port-write memory whose read data is
// registered ahead of use; strict channel alternation keeps that read
// fresh for back-to-back items.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and is meant to be written while the block is idle.
// Reset (rst_n low) empties the pipeline and restores configuration, state
// and averages to their start values; rings read as zero until filled.
`default_nettype none

module supply_monitor_overcurrent_ctrl_core
    import smoc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [SAMPLE_W-1:0]  sample,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      dac_load,
    output logic [CODE_BITS-1:0]      dac_code,
    output logic [VAL_W-1:0]          volt_readout,
    output logic [VAL_W-1:0]          curr_readout,
    output logic                      overcurrent,
    output logic                      check_done,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // configuration
    logic [VAL_W-1:0]    threshold_reg;
    logic [PERIOD_W-1:0] dac_period_reg;
    logic [PERIOD_W-1:0] check_period_reg;

    // control state
    logic                phase_reg;
    logic [PERIOD_W-1:0] check_ticks_reg;
    logic [PERIOD_W-1:0] dac_ticks_reg;
    logic [SLOT_W-1:0]   volt_slot_reg;
    logic [SLOT_W-1:0]   curr_slot_reg;
    logic                volt_full_reg;
    logic                curr_full_reg;
    logic [SUM_W-1:0]    volt_sum_reg;
    logic [SUM_W-1:0]    curr_sum_reg;
    logic [VAL_W-1:0]    vavg_reg;
    logic [VAL_W-1:0]    cavg_reg;
    logic [VAL_W-1:0]    last_curr_avg_reg;
    logic [VAL_W-1:0]    history_reg [HISTORY_DEPTH];
    logic [HSLOT_W-1:0]  hist_slot_reg;
    logic [HSUM_W-1:0]   hsum_reg;
    logic                protect_mode_reg;
    logic [CODE_BITS-1:0] last_code_reg;

    // pipeline valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, out_valid_reg;

    // pipeline payload
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_chan_reg, s2_chan_reg;
    logic                s1_chk_reg, s2_chk_reg, s3_chk_reg, s4_chk_reg;
    logic                s5_chk_reg, s6_chk_reg;
    logic                s1_load_reg, s2_load_reg, s3_load_reg, s4_load_reg;
    logic                s5_load_reg, s6_load_reg;
    logic [VAL_W-1:0]    s4_vavg_reg, s4_cavg_reg, s5_vavg_reg, s5_cavg_reg;
    logic [VAL_W-1:0]    s6_vavg_reg, s6_cavg_reg;
    logic                s5_mode_reg, s6_mode_reg;
    logic [PROD_W-1:0]   s6_prod_i_reg, s6_prod_v_reg;

    // result register
    logic                 dac_load_reg;
    logic [CODE_BITS-1:0] dac_code_reg;
    logic [VAL_W-1:0]     volt_readout_reg;
    logic [VAL_W-1:0]     curr_readout_reg;
    logic                 overcurrent_reg;
    logic                 check_done_reg;

    // ring memories
    logic [VAL_W-1:0] volt_ring_mem [RING_DEPTH];
    logic [VAL_W-1:0] curr_ring_mem [RING_DEPTH];
    logic [VAL_W-1:0] volt_rd_reg;
    logic [VAL_W-1:0] curr_rd_reg;

    logic adv;
    logic in_fire;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign in_fire   = in_valid && adv;
    assign cfg_ready = 1'b1;

    // tick counters at accept
    logic [PERIOD_W-1:0] check_ticks_inc, dac_ticks_inc;
    logic                check_hit, dac_hit;

    assign check_ticks_inc = check_ticks_reg + PERIOD_W'(1);
    assign dac_ticks_inc   = dac_ticks_reg + PERIOD_W'(1);
    assign check_hit       = check_ticks_inc >= check_period_reg;
    assign dac_hit         = dac_ticks_inc >= dac_period_reg;

    // stage 1: scale and ring update
    logic [SCALE_W-1:0] scale_prod;
    logic [VAL_W-1:0]   scaled;
    logic [VAL_W-1:0]   volt_old, curr_old;
    logic               s1_fire;
    logic               volt_we, curr_we;
    logic [SLOT_W-1:0]  volt_slot_next, curr_slot_next;
    logic               volt_wrap, curr_wrap;

    assign s1_fire    = adv && s1_valid_reg;
    assign scale_prod = SCALE_W'(s1_sample_reg) *
                        SCALE_W'((s1_chan_reg == CH_VOLT) ? GAIN_VOLT_SCALE
                                                           : GAIN_CURR_SCALE);
    assign scaled     = scale_prod[FRAC_BITS +: VAL_W];
    assign volt_old   = volt_full_reg ? volt_rd_reg : '0;
    assign curr_old   = curr_full_reg ? curr_rd_reg : '0;
    assign volt_we    = s1_fire && (s1_chan_reg == CH_VOLT);
    assign curr_we    = s1_fire && (s1_chan_reg == CH_CURR);
    assign volt_wrap  = volt_slot_reg == SLOT_W'(RING_DEPTH - 1);
    assign curr_wrap  = curr_slot_reg == SLOT_W'(RING_DEPTH - 1);
    assign volt_slot_next = volt_wrap ? '0 : volt_slot_reg + SLOT_W'(1);
    assign curr_slot_next = curr_wrap ? '0 : curr_slot_reg + SLOT_W'(1);

    always_ff @(posedge clk)
    begin
        if (volt_we)
        begin
            volt_ring_mem[volt_slot_reg] <= scaled;
        end
        volt_rd_reg <= volt_ring_mem[volt_slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (curr_we)
        begin
            curr_ring_mem[curr_slot_reg] <= scaled;
        end
        curr_rd_reg <= curr_ring_mem[curr_slot_reg];
    end

    // stage 2: average of the updated channel
    logic [SUM_W-1:0]      avg_sum_sel;
    logic [AVG_PROD_W-1:0] avg_prod, avg_quo;
    logic [VAL_W-1:0]      avg_new;

    assign avg_sum_sel = (s2_chan_reg == CH_VOLT) ? volt_sum_reg : curr_sum_reg;
    assign avg_prod    = AVG_PROD_W'(avg_sum_sel) * AVG_PROD_W'(AVG_RECIP);
    assign avg_quo     = avg_prod >> AVG_SHIFT;
    assign avg_new     = (avg_quo > AVG_PROD_W'(VAL_MAX)) ? VAL_W'(VAL_MAX)
                                                          : avg_quo[VAL_W-1:0];

    // stage 3: history update
    logic [HSLOT_W-1:0] hist_slot_next;
    logic [HSUM_W-1:0]  hsum_next;

    assign hist_slot_next = (hist_slot_reg == HSLOT_W'(HISTORY_DEPTH - 1))
                            ? '0 : hist_slot_reg + HSLOT_W'(1);
    assign hsum_next = hsum_reg - HSUM_W'(history_reg[hist_slot_reg])
                       + HSUM_W'(last_curr_avg_reg);

    // stage 4: history mean against threshold
    logic [H_PROD_W-1:0] h_prod, h_mean;
    logic                mode_next;

    assign h_prod    = H_PROD_W'(hsum_reg) * H_PROD_W'(H_RECIP);
    assign h_mean    = h_prod >> H_SHIFT;
    assign mode_next = s4_chk_reg ? (h_mean >= H_PROD_W'(threshold_reg))
                                  : protect_mode_reg;

    // stage 5: control mix products
    logic [PROD_W-1:0] prod_i, prod_v;

    assign prod_i = PROD_W'(s5_cavg_reg) *
                    PROD_W'(s5_mode_reg ? GAIN_I_PROTECT : GAIN_I_NORMAL);
    assign prod_v = PROD_W'(s5_vavg_reg) *
                    PROD_W'(s5_mode_reg ? GAIN_V_PROTECT : GAIN_V_NORMAL);

    // stage 6: code saturation and displays
    logic [MIX_W-1:0]     mix, mix_q;
    logic [CODE_BITS-1:0] code_new;
    logic [VAL_W:0]       vdisp_wide;
    logic [VAL_W-1:0]     vdisp, cdisp;

    assign mix   = {1'b0, s6_prod_i_reg} - {1'b0, s6_prod_v_reg};
    assign mix_q = mix >> FRAC_BITS;

    always_comb
    begin
        if (mix[MIX_W-1] || (mix == '0))
        begin
            code_new = '0;
        end
        else if (mix_q > MIX_W'(CODE_MAX))
        begin
            code_new = CODE_BITS'(CODE_MAX);
        end
        else
        begin
            code_new = mix_q[CODE_BITS-1:0];
        end
    end

    assign vdisp_wide = {1'b0, s6_vavg_reg} + {1'b0, VOLT_OFFSET};

    always_comb
    begin
        if (s6_mode_reg)
        begin
            vdisp = (vdisp_wide > (VAL_W + 1)'(VAL_MAX)) ? VAL_W'(VAL_MAX)
                                                         : vdisp_wide[VAL_W-1:0];
            cdisp = (s6_cavg_reg > CURR_OFFSET) ? s6_cavg_reg - CURR_OFFSET : '0;
        end
        else
        begin
            vdisp = s6_vavg_reg;
            cdisp = s6_cavg_reg;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= THRESHOLD_RESET;
            dac_period_reg    <= DAC_PERIOD_RESET;
            check_period_reg  <= CHECK_PERIOD_RESET;
            phase_reg         <= 1'b0;
            check_ticks_reg   <= '0;
            dac_ticks_reg     <= '0;
            volt_slot_reg     <= '0;
            curr_slot_reg     <= '0;
            volt_full_reg     <= 1'b0;
            curr_full_reg     <= 1'b0;
            volt_sum_reg      <= '0;
            curr_sum_reg      <= '0;
            vavg_reg          <= '0;
            cavg_reg          <= '0;
            last_curr_avg_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                history_reg[i] <= '0;
            end
            hist_slot_reg     <= '0;
            hsum_reg          <= '0;
            protect_mode_reg  <= 1'b0;
            last_code_reg     <= CODE_RESET;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            s4_valid_reg      <= 1'b0;
            s5_valid_reg      <= 1'b0;
            s6_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CURRENT_THRESHOLD: threshold_reg    <= cfg_data[VAL_W-1:0];
                    REG_DAC_PERIOD:        dac_period_reg   <= cfg_data[PERIOD_W-1:0];
                    REG_CHECK_PERIOD:      check_period_reg <= cfg_data[PERIOD_W-1:0];
                    default:               ;
                endcase
            end

            if (in_fire)
            begin
                phase_reg       <= ~phase_reg;
                check_ticks_reg <= check_hit ? '0 : check_ticks_inc;
                dac_ticks_reg   <= dac_hit ? '0 : dac_ticks_inc;
            end

            if (volt_we)
            begin
                volt_sum_reg  <= volt_sum_reg - SUM_W'(volt_old) + SUM_W'(scaled);
                volt_slot_reg <= volt_slot_next;
                if (volt_wrap)
                begin
                    volt_full_reg <= 1'b1;
                end
            end

            if (curr_we)
            begin
                curr_sum_reg  <= curr_sum_reg - SUM_W'(curr_old) + SUM_W'(scaled);
                curr_slot_reg <= curr_slot_next;
                if (curr_wrap)
                begin
                    curr_full_reg <= 1'b1;
                end
            end

            if (adv && s2_valid_reg)
            begin
                if (s2_chan_reg == CH_VOLT)
                begin
                    vavg_reg <= avg_new;
                end
                else
                begin
                    cavg_reg <= avg_new;
                end
            end

            if (adv && s3_valid_reg)
            begin
                last_curr_avg_reg <= cavg_reg;
                if (s3_chk_reg)
                begin
                    history_reg[hist_slot_reg] <= last_curr_avg_reg;
                    hist_slot_reg              <= hist_slot_next;
                    hsum_reg                   <= hsum_next;
                end
            end

            if (adv && s4_valid_reg)
            begin
                protect_mode_reg <= mode_next;
            end

            if (adv && s6_valid_reg)
            begin
                last_code_reg <= code_new;
            end

            if (adv)
            begin
                s1_valid_reg  <= in_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                s5_valid_reg  <= s4_valid_reg;
                s6_valid_reg  <= s5_valid_reg;
                out_valid_reg <= s6_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sample_reg <= sample;
            s1_chan_reg   <= ~phase_reg;
            s1_chk_reg    <= check_hit;
            s1_load_reg   <= dac_hit;

            s2_chan_reg   <= s1_chan_reg;
            s2_chk_reg    <= s1_chk_reg;
            s2_load_reg   <= s1_load_reg;

            s3_chk_reg    <= s2_chk_reg;
            s3_load_reg   <= s2_load_reg;

            s4_chk_reg    <= s3_chk_reg;
            s4_load_reg   <= s3_load_reg;
            s4_vavg_reg   <= vavg_reg;
            s4_cavg_reg   <= cavg_reg;

            s5_chk_reg    <= s4_chk_reg;
            s5_load_reg   <= s4_load_reg;
            s5_vavg_reg   <= s4_vavg_reg;
            s5_cavg_reg   <= s4_cavg_reg;
            s5_mode_reg   <= mode_next;

            s6_chk_reg    <= s5_chk_reg;
            s6_load_reg   <= s5_load_reg;
            s6_vavg_reg   <= s5_vavg_reg;
            s6_cavg_reg   <= s5_cavg_reg;
            s6_mode_reg   <= s5_mode_reg;
            s6_prod_i_reg <= prod_i;
            s6_prod_v_reg <= prod_v;

            dac_load_reg     <= s6_load_reg;
            dac_code_reg     <= s6_load_reg ? last_code_reg : '0;
            volt_readout_reg <= vdisp;
            curr_readout_reg <= cdisp;
            overcurrent_reg  <= s6_mode_reg;
            check_done_reg   <= s6_chk_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dac_load     = dac_load_reg;
    assign dac_code     = dac_code_reg;
    assign volt_readout = volt_readout_reg;
    assign curr_readout = curr_readout_reg;
    assign overcurrent  = overcurrent_reg;
    assign check_done   = check_done_reg;

    // adjacent ring stages always carry opposite channels
    a_chan_alternate: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s2_valid_reg |-> s1_chan_reg != s2_chan_reg)
        else $error("adjacent items on the same channel");

    // mode only moves on a check
    a_mode_on_check: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(protect_mode_reg) |-> $past(adv && s4_valid_reg && s4_chk_reg))
        else $error("protect mode changed without a check");

    // no code leaves without a load
    a_code_gated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dac_load |-> dac_code == '0)
        else $error("dac code without load");

    a_slots_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (volt_slot_reg < SLOT_W'(RING_DEPTH)) && (curr_slot_reg < SLOT_W'(RING_DEPTH))
        && (hist_slot_reg < HSLOT_W'(HISTORY_DEPTH)))
        else $error("slot out of range");

    // overcurrent display keeps its voltage offset
    a_volt_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overcurrent |-> volt_readout >= VOLT_OFFSET)
        else $error("overcurrent voltage display below offset");

endmodule

`default_nettype wire
